FILE: rtl/bccrg_pkg.sv
// Package for the carry-chain random byte generator.
// Holds the seed table, request codes and sequencer states; no dependencies.
`default_nettype none

package bccrg_pkg;

  // State size and draw limit for ranged requests
  localparam int unsigned NumBytes = 16;
  localparam int unsigned IdxW     = $clog2(NumBytes);
  localparam int unsigned MaxDraws = 4096;
  localparam int unsigned DrawCntW = $clog2(MaxDraws);

  // Request kinds carried on tuser
  localparam logic ACT_RAW   = 1'b0;
  localparam logic ACT_RANGE = 1'b1;

  // Reset value of the state bytes, byte 0 first
  localparam logic [7:0] SEED_TABLE [NumBytes] = '{
    8'h64, 8'h76, 8'h85, 8'h54, 8'hF6, 8'h5C, 8'h76, 8'h1F,
    8'hE7, 8'h12, 8'hA7, 8'h6B, 8'h93, 8'hC4, 8'h6E, 8'h1B
  };

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_CHECK,
    ST_DELIVER
  } state_e;

endpackage : bccrg_pkg

`default_nettype wire

FILE: rtl/byte_carry_chain_random_generator.sv
// Top level of the carry-chain random byte generator.
// Depends on bccrg_pkg for the seed table, request codes and states.
`default_nettype none

// One draw walks the carry chain through a single shared 8-bit adder, one state
// byte per cycle from byte 14 down to byte 0, and the check state then tests the
// result. A raw request returns the result of its first draw; an empty or
// single-value range (low bound not below high bound) goes from idle straight
// to the deliver state and returns the low bound without touching the state. A
// ranged request repeats draws until one lands in the bounds, at most 4096
// draws, and returns the low bound if none does. The block takes one request
// at a time; the output register lets it take the next request while a result
// still waits on the master side.
module byte_carry_chain_random_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request: tdata = {high_bound[15:8], low_bound[7:0]}, tuser = action
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,
  input  wire logic        s_axis_tuser_i,
  // result: tdata = value[7:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o
);
  import bccrg_pkg::*;

  state_e               state_q, state_d;
  logic [7:0]           bytes_q [NumBytes];
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [7:0]           sum_q, sum_d;
  logic                 carry_q, carry_d;
  logic [DrawCntW-1:0]  cnt_q, cnt_d;
  logic                 action_q;
  logic [7:0]           low_q, high_q;
  logic [7:0]           result_q, result_d;
  logic                 out_valid_q;
  logic [7:0]           out_data_q;

  logic                 in_xfer;
  logic                 step_en;
  logic [8:0]           add_sum;
  logic [7:0]           new_byte;
  logic                 load_out;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Shared adder: running sum plus current byte plus carry
  assign add_sum  = {1'b0, sum_q} + {1'b0, bytes_q[idx_q]} + {8'd0, carry_q};
  assign new_byte = add_sum[7:0] + 8'd1;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    carry_d  = carry_q;
    cnt_d    = cnt_q;
    result_d = result_q;
    step_en  = 1'b0;
    load_out = 1'b0;
    s_axis_tready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cnt_d   = '0;
          sum_d   = bytes_q[NumBytes-1];
          carry_d = 1'b0;
          idx_d   = IdxW'(NumBytes - 2);
          if (s_axis_tuser_i == ACT_RANGE &&
              s_axis_tdata_i[7:0] >= s_axis_tdata_i[15:8]) begin
            // empty or single range: answer with the low bound
            result_d = s_axis_tdata_i[7:0];
            state_d  = ST_DELIVER;
          end else begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        step_en = 1'b1;
        sum_d   = add_sum[7:0];
        carry_d = add_sum[8];
        if (idx_q == '0) begin
          result_d = new_byte;
          state_d  = ST_CHECK;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_CHECK: begin
        if (action_q == ACT_RAW) begin
          state_d = ST_DELIVER;
        end else if (result_q >= low_q && result_q <= high_q) begin
          state_d = ST_DELIVER;
        end else if (cnt_q == {DrawCntW{1'b1}}) begin
          // range never hit
          result_d = low_q;
          state_d  = ST_DELIVER;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          sum_d   = bytes_q[NumBytes-1];
          carry_d = 1'b0;
          idx_d   = IdxW'(NumBytes - 2);
          state_d = ST_DRAW;
        end
      end
      ST_DELIVER: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // State bytes: write back the chain byte, bump byte 15 at the end of a draw
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBytes; i++) begin
        bytes_q[i] <= SEED_TABLE[i];
      end
    end else if (step_en) begin
      bytes_q[idx_q] <= new_byte;
      if (idx_q == '0) begin
        bytes_q[NumBytes-1] <= bytes_q[NumBytes-1] + 8'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    sum_q    <= sum_d;
    carry_q  <= carry_d;
    cnt_q    <= cnt_d;
    result_q <= result_d;
    if (in_xfer) begin
      action_q <= s_axis_tuser_i;
      low_q    <= s_axis_tdata_i[7:0];
      high_q   <= s_axis_tdata_i[15:8];
    end
    if (load_out) begin
      out_data_q <= result_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule : byte_carry_chain_random_generator

`default_nettype wire

FILE: rtl/bccrg_checker.sv
// Port-level checks for the carry-chain random byte generator.
// Bound to byte_carry_chain_random_generator; uses no package items.
`default_nettype none

module bccrg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic        s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o
);

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Waiting request holds its fields
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i))
    else $error("request changed while waiting");

  // One request at a time: busy after a transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while busy");

  // No result appears in the cycle right after a request transfer
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result shown too early");

  // A new result comes out only as the block returns to idle
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result delivered while still busy");

endmodule : bccrg_checker

bind byte_carry_chain_random_generator bccrg_checker u_bccrg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
